>>> hw/rtl/fp_round_to_integral_top_defines.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef FP_ROUND_TO_INTEGRAL_TOP_DEFINES_SVH
`define FP_ROUND_TO_INTEGRAL_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define FRI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define FRI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/fri_pkg.sv
// Package for the round-to-integral block: codes and field widths.
// No dependencies.
package fri_pkg;
	localparam int unsigned OpW = 64;

	typedef enum logic [1:0] {
		RM_NEAREST = 2'd0,
		RM_ZERO    = 2'd1,
		RM_PINF    = 2'd2,
		RM_MINF    = 2'd3
	} rmode_t;

	typedef enum logic [1:0] {
		EXC_NONE    = 2'd0,
		EXC_INVALID = 2'd1,
		EXC_INEXACT = 2'd2,
		EXC_RSVD    = 2'd3
	} exc_t;

	typedef enum logic [1:0] {
		REG_RMODE  = 2'd0,
		REG_INV_TE = 2'd1,
		REG_INX_TE = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [OpW-1:0] rounded;
		exc_t           exc;
		logic           raise_invalid;
		logic           raise_inexact;
	} result_t;
endpackage

>>> hw/rtl/fri_core.sv
// Combinational round-to-integral for binary32 and binary64.
// Depends on fri_pkg.
module fri_core import fri_pkg::*; (
	input  logic [OpW-1:0] operand,
	input  logic           is_double,
	input  rmode_t         rmode,
	input  logic           inv_te,
	input  logic           inx_te,
	output result_t        res
);
	logic [10:0] expf, emask, bias;
	logic [51:0] frac, qbit, fmask;
	logic [5:0]  m;
	logic        sign;
	logic [11:0] ue;
	logic [5:0]  sh;
	logic [52:0] mant, lowmask, rem, halfb, r0;
	logic [53:0] r1, rsh;
	logic        inc, rnz, is_nan, big, ge1, exact_zero;
	logic [63:0] x, sbit, outv;
	logic [11:0] newexp;
	logic        inexact;

	always_comb begin
		x     = is_double ? operand : {32'd0, operand[31:0]};
		m     = is_double ? 6'd52 : 6'd23;
		emask = is_double ? 11'h7ff : 11'h0ff;
		bias  = is_double ? 11'h3ff : 11'h07f;
		fmask = is_double ? {52{1'b1}} : {29'd0, {23{1'b1}}};
		qbit  = is_double ? (52'd1 << 51) : (52'd1 << 22);
		expf  = is_double ? x[62:52] : {3'd0, x[30:23]};
		frac  = x[51:0] & fmask;
		sign  = is_double ? x[63] : x[31];
		sbit  = is_double ? (64'd1 << 63) : (64'd1 << 31);
		is_nan = (expf == emask);
		big    = ({1'b0, expf} >= ({1'b0, bias} + {6'd0, m}));
		ge1    = (expf >= bias);
		// shift amount m - (expf - bias), valid when ge1 and not big
		ue   = {1'b0, expf} - {1'b0, bias};
		sh   = m - ue[5:0];
		mant = {1'b0, frac} | ({52'd0, 1'b1} << m);
		lowmask = ({52'd0, 1'b1} << sh) - 53'd1;
		rem   = mant & lowmask;
		halfb = ({52'd0, 1'b1} << (sh - 6'd1));
		r0    = mant >> sh;
		rnz   = (rem != '0);
		case (rmode)
			RM_PINF:    inc = rnz & ~sign;
			RM_MINF:    inc = rnz & sign;
			RM_NEAREST: inc = ((rem & halfb) != '0) &&
				(((rem & (halfb - 53'd1)) != '0) || r0[0]);
			default:    inc = 1'b0;
		endcase
		r1  = {1'b0, r0} + {53'd0, inc};
		rsh = r1 << sh;
		newexp = {1'b0, expf} + {11'd0, (rsh >> (m + 6'd1)) != '0};
		exact_zero = (expf == '0) && (frac == '0);

		res = '{rounded: '0, exc: EXC_NONE, raise_invalid: 1'b0, raise_inexact: 1'b0};
		inexact = 1'b0;
		outv = '0;
		if (is_nan) begin
			if ((frac & qbit) != '0) begin
				if (inv_te) begin
					res.exc = EXC_INVALID;
				end else begin
					res.rounded = x & ~{12'd0, qbit};
					res.raise_invalid = 1'b1;
				end
			end else begin
				res.rounded = x;
			end
		end else begin
			if (big) begin
				outv = x;
			end else if (ge1) begin
				inexact = rnz;
				outv = (sign ? sbit : 64'd0) | ({53'd0, newexp[10:0] & emask} << m)
					| {12'd0, rsh[51:0] & fmask};
			end else begin
				outv = sign ? sbit : 64'd0;
				if (!exact_zero) begin
					inexact = 1'b1;
					if ((rmode == RM_PINF && !sign) || (rmode == RM_MINF && sign) ||
						(rmode == RM_NEAREST && expf == bias - 11'd1 && frac != '0)) begin
						outv = outv | ({53'd0, bias} << m);
					end
				end
			end
			res.rounded = outv;
			if (inexact) begin
				if (inx_te) res.exc = EXC_INEXACT;
				else res.raise_inexact = 1'b1;
			end
		end
		if (!is_double) res.rounded[63:32] = '0;
	end
endmodule

>>> hw/rtl/fp_round_to_integral_top.sv
// Round-to-integral top level: stream channels, APB registers, one stage.
// Depends on fri_pkg and fri_core.
//
// Usage: items enter on s_axis (tdata = operand[63:0], tuser = is_double)
// and leave on m_axis (tdata = rounded[63:0], exception_code[65:64],
// raise_invalid[66], raise_inexact[67], zero fill to 72 bits).
// Registers on APB: 0x0 round mode select, 0x4 invalid_trap_enable,
// 0x8 inexact_trap_enable; write only while idle.
// A result is valid in the cycle after its input is accepted.
// One item per cycle unless the receiver stalls; the result register is the only
// stage, fed by the combinational rounder (shifter and incrementer).
// s_axis_tready is high while the result register is empty or being
// drained this cycle, so a stalled receiver holds the result and
// stalls the input side.
// Reset clears the result valid and all configuration registers to zero (nearest
// even, traps disabled).
module fp_round_to_integral_top import fri_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // operand
	input  logic        s_axis_tuser,   // is_double
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // rounded, exception_code, raise_invalid, raise_inexact
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	rmode_t  rmode_q;
	logic    inv_te_q, inx_te_q, valid_q;
	result_t comb_res, res_q;
	reg_idx_t ridx;

	assign pready = 1'b1;
	assign ridx = reg_idx_t'(paddr[3:2]);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmode_q  <= RM_NEAREST;
			inv_te_q <= 1'b0;
			inx_te_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_RMODE:  rmode_q  <= rmode_t'(pwdata[1:0]);
				REG_INV_TE: inv_te_q <= pwdata[0];
				REG_INX_TE: inx_te_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (ridx)
			REG_RMODE:  prdata = {30'd0, rmode_q};
			REG_INV_TE: prdata = {31'd0, inv_te_q};
			REG_INX_TE: prdata = {31'd0, inx_te_q};
			default:    prdata = '0;
		endcase
	end

	fri_core u_core (
		.operand  (s_axis_tdata),
		.is_double(s_axis_tuser),
		.rmode    (rmode_q),
		.inv_te   (inv_te_q),
		.inx_te   (inx_te_q),
		.res      (comb_res)
	);

	assign s_axis_tready = !valid_q || m_axis_tready;

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (s_axis_tready) valid_q <= s_axis_tvalid;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) res_q <= comb_res;
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {4'd0, res_q.raise_inexact, res_q.raise_invalid, res_q.exc,
		res_q.rounded};
endmodule

>>> hw/rtl/fri_checker.sv
// Port-level checker for the round-to-integral block, bound to the top.
// Depends on fp_round_to_integral_top_defines.svh.
`include "fp_round_to_integral_top_defines.svh"
module fri_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata
);
	// a stalled result holds its value
	`FRI_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
	// an accepted item shows up in the next cycle
	`FRI_ASSERT_NEXT(a_lat, clk, arst_n, s_axis_tvalid && s_axis_tready,
		m_axis_tvalid, "accepted item did not produce a result")
	// exception code never reserved, flags exclusive with a trap
	`FRI_ASSERT_IMP(a_exc, clk, arst_n, m_axis_tvalid,
		m_axis_tdata[65:64] != 2'd3 &&
		!(m_axis_tdata[65:64] != 2'd0 && (m_axis_tdata[66] || m_axis_tdata[67])),
		"bad exception code or flags")
	// input is ready whenever the output is empty
	`FRI_ASSERT_IMP(a_rdy, clk, arst_n, !m_axis_tvalid, s_axis_tready,
		"input stalled with empty output")
endmodule

bind fp_round_to_integral_top fri_checker u_fri_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

>>> sim/fp_round_to_integral_top_test.sv
// Testbench for fp_round_to_integral_top: stream stimulus, APB register setup,
// scoreboard with a bit-accurate round-to-integral predictor. Depends on fri_pkg.
`timescale 1ns / 1ps

module fp_round_to_integral_top_test;
	import fri_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	// Predicted result for one accepted operand
	typedef struct packed {
		logic [63:0] rounded;
		exc_t        exc;
		logic        raise_invalid;
		logic        raise_inexact;
	} rint_t;

	// Scoreboard: holds the rounding setup and the queue of pending results
	class rint_scoreboard;
		rmode_t mode;
		bit     inv_te;
		bit     inx_te;
		rint_t  pending[$];
		int     errors;
		int     checked;

		function new();
			mode = RM_NEAREST;
			inv_te = 0;
			inx_te = 0;
			errors = 0;
			checked = 0;
		endfunction

		// Round one value with m fraction and e exponent bits
		function rint_t round_fmt(logic [63:0] x, int m, int e);
			rint_t r;
			logic [63:0] fmask, emask, signb, bias, expf, frac, sgn;
			logic [63:0] mant, q, rem, half, newexp, qbit;
			int ue, sh;
			bit inexact;
			r = '0;
			inexact = 0;
			fmask = (64'd1 << m) - 1;
			emask = (64'd1 << e) - 1;
			signb = 64'd1 << (m + e);
			bias = emask >> 1;
			expf = (x >> m) & emask;
			frac = x & fmask;
			sgn = x & signb;
			r.exc = EXC_NONE;
			if (expf == emask) begin
				qbit = 64'd1 << (m - 1);
				if ((frac & qbit) != 0) begin
					if (inv_te) begin
						r.exc = EXC_INVALID;
						return r;
					end
					x = x & ~qbit;
					r.raise_invalid = 1;
				end
				r.rounded = x;
				return r;
			end
			if (expf >= bias + m) begin
				r.rounded = x;
				return r;
			end
			if (expf >= bias) begin
				ue = int'(expf - bias);
				sh = m - ue;
				mant = frac | (64'd1 << m);
				q = mant >> sh;
				rem = mant & ((64'd1 << sh) - 1);
				half = 64'd1 << (sh - 1);
				if (rem != 0) begin
					inexact = 1;
					case (mode)
						RM_PINF: if (sgn == 0) q = q + 1;
						RM_MINF: if (sgn != 0) q = q + 1;
						RM_NEAREST: begin
							if ((rem & half) != 0 && ((rem & (half - 1)) != 0 || q[0]))
								q = q + 1;
						end
						default: ;
					endcase
				end
				q = q << sh;
				newexp = ((q >> (m + 1)) != 0) ? expf + 1 : expf;
				r.rounded = sgn | ((newexp & emask) << m) | (q & fmask);
			end else begin
				r.rounded = sgn;
				if ((expf | frac) != 0) begin
					inexact = 1;
					case (mode)
						RM_PINF: if (sgn == 0) r.rounded = r.rounded | (bias << m);
						RM_MINF: if (sgn != 0) r.rounded = r.rounded | (bias << m);
						RM_NEAREST: begin
							if (expf == bias - 1 && frac != 0)
								r.rounded = r.rounded | (bias << m);
						end
						default: ;
					endcase
				end
			end
			if (inexact) begin
				if (inx_te) r.exc = EXC_INEXACT;
				else r.raise_inexact = 1;
			end
			return r;
		endfunction

		function void note_operand(logic [63:0] op, bit dbl);
			rint_t r;
			if (dbl) begin
				r = round_fmt(op, 52, 11);
			end else begin
				r = round_fmt({32'd0, op[31:0]}, 23, 8);
				r.rounded[63:32] = '0;
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [71:0] d);
			rint_t want;
			rint_t got;
			got.rounded = d[63:0];
			got.exc = exc_t'(d[65:64]);
			got.raise_invalid = d[66];
			got.raise_inexact = d[67];
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, d);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.rounded !== want.rounded) begin
				$display("%0t: rounded exp %h got %h", $time, want.rounded, got.rounded);
				errors++;
			end
			if (got.exc !== want.exc) begin
				$display("%0t: exception exp %0d got %0d", $time, want.exc, got.exc);
				errors++;
			end
			if (got.raise_invalid !== want.raise_invalid) begin
				$display("%0t: invalid flag exp %0b got %0b", $time,
					want.raise_invalid, got.raise_invalid);
				errors++;
			end
			if (got.raise_inexact !== want.raise_inexact) begin
				$display("%0t: inexact flag exp %0b got %0b", $time,
					want.raise_inexact, got.raise_inexact);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;   // operand
	logic        s_axis_tuser;   // is_double
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;   // rounded, exception_code, raise_invalid, raise_inexact
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rint_scoreboard sb;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_off;
	int  sent;
	int  idle_cycles;

	fp_round_to_integral_top uut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Output side: random stalls, forced hold-off, checking on accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles with no stream handshake and no APB select
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| psel)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress, %0d results pending", sb.pending.size());
				$display("** fp_round_to_integral_top: FAILED **");
				$finish;
			end
		end
	end

	task automatic apb_write(reg_idx_t idx, logic [31:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_RMODE: sb.mode = rmode_t'(val[1:0]);
			REG_INV_TE: sb.inv_te = val[0];
			REG_INX_TE: sb.inx_te = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(rmode_t md, bit inv, bit inx);
		apb_write(REG_RMODE, {30'd0, md});
		apb_write(REG_INV_TE, {31'd0, inv});
		apb_write(REG_INX_TE, {31'd0, inx});
	endtask

	// Offer one item, holding it until accepted
	task automatic send_operand(logic [63:0] op, bit dbl);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= op;
		s_axis_tuser <= dbl;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_operand(op, dbl);
		sent++;
	endtask

	task automatic drain;
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Random operand biased toward exponents near the integral threshold
	function automatic logic [63:0] rand_operand(bit dbl);
		logic [63:0] v;
		int k;
		v = {$urandom, $urandom};
		k = $urandom_range(9);
		if (dbl) begin
			if (k < 6) v[62:52] = 11'(1023 - 3 + $urandom_range(58));
			else if (k == 6) v[62:52] = '1;
			else if (k == 7) v[62:52] = '0;
		end else begin
			if ($urandom_range(3) != 0) v[63:32] = '0;
			if (k < 6) v[30:23] = 8'(127 - 3 + $urandom_range(29));
			else if (k == 6) v[30:23] = '1;
			else if (k == 7) v[30:23] = '0;
		end
		if ($urandom_range(3) == 0) v[31:0] = {v[31], v[30:23] & 8'hff, 23'h400000};
		return v;
	endfunction

	task automatic directed;
		send_operand(64'h0000_0000_3f00_0000, 0);  // 0.5
		send_operand(64'h0000_0000_bf00_0001, 0);  // just below -0.5
		send_operand(64'h0000_0000_3fc0_0000, 0);  // 1.5
		send_operand(64'h0000_0000_4020_0000, 0);  // 2.5
		send_operand(64'h0000_0000_7f80_0000, 0);  // +inf
		send_operand(64'h0000_0000_7fc0_0000, 0);  // NaN, top fraction bit only
		send_operand(64'h0000_0000_ffa0_0001, 0);  // NaN, top bit clear
		send_operand(64'h0000_0000_0000_0001, 0);  // subnormal
		send_operand(64'h0000_0000_8000_0000, 0);  // -0
		send_operand(64'h0000_0000_4b7f_ffff, 0);  // large, integral
		send_operand(64'h0000_0000_4affffff, 0);  // carry into exponent
		send_operand(64'hffff_ffff_3f7f_ffff, 0);  // upper bits set
		send_operand(64'h3fe0_0000_0000_0000, 1);  // 0.5
		send_operand(64'h3ff8_0000_0000_0000, 1);  // 1.5
		send_operand(64'hc004_0000_0000_0000, 1);  // -2.5
		send_operand(64'h4330_0000_0000_0000, 1);  // 2^52
		send_operand(64'h432f_ffff_ffff_ffff, 1);  // carry into exponent
		send_operand(64'h7ff8_0000_0000_0000, 1);  // NaN, top fraction bit only
		send_operand(64'hfff4_0000_0000_0001, 1);  // NaN, top bit clear
		send_operand(64'h0000_0000_0000_0001, 1);  // subnormal
		send_operand(64'hffff_ffff_ffff_ffff, 1);
		send_operand(64'h0000_0000_0000_0000, 1);
	endtask

	initial begin
		int unsigned ph;
		int pct_s[4] = '{0, 61, 0, 35};
		int pct_r[4] = '{0, 0, 61, 35};
		sb = new();
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 0;
		sent = 0;
		idle_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed values under every mode, each with a different trap setting
		for (int md = 0; md < 4; md++) begin
			set_config(rmode_t'(md), md[0], md[1]);
			directed();
			drain();
		end

		// Long receiver hold-off while items keep coming
		fork
			begin
				hold_off = 1;
				repeat (40) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 20; i++) send_operand(rand_operand(i[0]), i[0]);
		join
		drain();

		// Random phases across idling patterns and configurations
		for (ph = 0; ph < 16; ph++) begin
			send_idle_pct = pct_s[ph % 4];
			recv_stall_pct = pct_r[ph % 4];
			set_config(rmode_t'($urandom_range(3)), $urandom_range(1), $urandom_range(1));
			for (int i = 0; i < 105; i++) begin
				bit dbl;
				dbl = $urandom_range(1);
				send_operand(rand_operand(dbl), dbl);
			end
			drain();
		end
		recv_stall_pct = 0;
		repeat (5) @(posedge clk);

		$display("Covered %0d items, %0d results checked, all modes and trap settings,",
			sent, sb.checked);
		$display("single and double, NaN, infinity, subnormal and tie cases.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("** fp_round_to_integral_top: PASSED **");
		else
			$display("** fp_round_to_integral_top: FAILED **");
		$finish;
	end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/fri_pkg.sv
hw/rtl/fri_core.sv
hw/rtl/fp_round_to_integral_top.sv
hw/rtl/fri_checker.sv
sim/fp_round_to_integral_top_test.sv
